>>> hdl/hmd_pkg.sv
// Shared types, widths and the CORDIC angle constants of the magnetometer heading block.
// The angle table is worked out at elaboration from integer series and depends on nothing else.
package hmd_pkg;

  // Fixed CORDIC geometry.
  localparam int unsigned CORDIC_STEPS = 62;
  localparam int unsigned CORDIC_WIDTH = 63;
  localparam int unsigned ANGLE_WIDTH  = 64;
  // Width of the signed y component while it is normalized; x and the magnitude use one bit less.
  localparam int unsigned NORM_WIDTH   = 61;
  localparam int unsigned NORM_MSB     = NORM_WIDTH - 2;

  typedef logic [ANGLE_WIDTH-1:0] angle_t;

  // One word in flight through the rotation stages.
  typedef struct packed {
    logic                           zero;
    logic signed [CORDIC_WIDTH-1:0] x;
    logic signed [CORDIC_WIDTH-1:0] y;
    angle_t                         z;
  } hmd_vec_t;

  // Restoring unsigned division, used only while constants are elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in Q62 radians by its alternating series.
  function automatic logic [63:0] atan_recip_q62(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv64(64'd1 << 62, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = udiv64(p, 64'(2 * k + 1));
        if ((k & 1) == 0) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        p = udiv64(udiv64(p, n), n);
      end
    end
    return sum;
  endfunction

  // floor(a * 2^64 / b) for a below b.
  function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] q;
    r = a;
    q = '0;
    for (int k = 0; k < 64; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rotation angle of one step in units of 2^-64 turn.
  function automatic angle_t cordic_angle(input int unsigned step);
    logic [63:0] quarter_pi;
    logic [63:0] a;
    quarter_pi = (atan_recip_q62(64'd5) << 2) - atan_recip_q62(64'd239);
    a          = atan_recip_q62(64'd1 << step);
    if (step == 0) begin
      return angle_t'(64'd1 << 61);
    end
    return angle_t'((frac_div(a, quarter_pi) + 64'd4) >> 3);
  endfunction

endpackage

>>> hdl/hmd_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation of the heading pipeline.
// Depends on hmd_pkg for the word type and the angle constants.
module hmd_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hmd_pkg::hmd_vec_t vec_i,
  output logic             valid_o,
  output hmd_pkg::hmd_vec_t vec_o
);
  import hmd_pkg::*;

  localparam angle_t ANGLE = cordic_angle(STEP);

  logic signed [CORDIC_WIDTH-1:0] x_in;
  logic signed [CORDIC_WIDTH-1:0] y_in;
  logic signed [CORDIC_WIDTH-1:0] x_sh;
  logic signed [CORDIC_WIDTH-1:0] y_sh;
  hmd_vec_t                       vec_d;
  hmd_vec_t                       vec_q;
  logic                           valid_q;

  assign x_in = vec_i.x;
  assign y_in = vec_i.y;
  assign x_sh = x_in >>> STEP;
  assign y_sh = y_in >>> STEP;

  // Rotate toward the x axis: a positive y turns clockwise, zero or negative y counterclockwise.
  always_comb begin
    vec_d.zero = vec_i.zero;
    if (y_in > 0) begin
      vec_d.x = x_in + y_sh;
      vec_d.y = y_in - x_sh;
      vec_d.z = vec_i.z + ANGLE;
    end else begin
      vec_d.x = x_in - y_sh;
      vec_d.y = y_in + x_sh;
      vec_d.z = vec_i.z - ANGLE;
    end
  end

  // The valid bit travels with the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> hdl/magnetometer_heading_degrees_top.sv
// Compass heading from a magnetometer sample: atan2(y, x) in 1/2^FRACTION_BITS degree, 0..<360.
// Takes one word per cycle.
// The pipeline is four input stages, 62 rotation stages and two output stages; every stage takes a new word each cycle.
// busy_o stays low; reset clears every valid bit, so no result appears after reset before a word is accepted.
// Depends on hmd_pkg and hmd_cordic_stage.
module magnetometer_heading_degrees_top #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  output logic                          done_o,
  output logic [9+FRACTION_BITS-1:0]    heading_o
);
  import hmd_pkg::*;

  localparam int unsigned HW     = 9 + FRACTION_BITS;
  localparam int unsigned PROD_W = 32 + HW;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned PAD_W  = NORM_WIDTH - 1 - SAMPLE_WIDTH;
  localparam logic [HW-1:0] FULL = HW'(360) << FRACTION_BITS;

  // Fold stage: a negative x turns the vector by a half turn.
  logic signed [SAMPLE_WIDTH:0] x_ext;
  logic signed [SAMPLE_WIDTH:0] y_ext;
  logic                         x_neg;
  logic                         p1_valid_q;
  logic signed [SAMPLE_WIDTH:0] p1_x_q;
  logic signed [SAMPLE_WIDTH:0] p1_y_q;
  logic                         p1_half_q;
  logic                         p1_zero_q;

  assign busy_o = 1'b0;
  assign x_ext  = {mag_x_i[SAMPLE_WIDTH-1], mag_x_i};
  assign y_ext  = {mag_y_i[SAMPLE_WIDTH-1], mag_y_i};
  assign x_neg  = mag_x_i[SAMPLE_WIDTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p1_x_q    <= x_neg ? -x_ext : x_ext;
      p1_y_q    <= x_neg ? -y_ext : y_ext;
      p1_half_q <= x_neg;
      p1_zero_q <= (mag_x_i == '0) && (mag_y_i == '0);
    end
  end

  // Magnitude stage: x is now non-negative, take |y| for the normalization search.
  logic                          p2_valid_q;
  logic [SAMPLE_WIDTH-1:0]       p2_x_q;
  logic [SAMPLE_WIDTH-1:0]       p2_ay_q;
  logic signed [SAMPLE_WIDTH:0]  p2_y_q;
  logic                          p2_half_q;
  logic                          p2_zero_q;
  logic [SAMPLE_WIDTH:0]         abs_y;

  assign abs_y = p1_y_q[SAMPLE_WIDTH] ? -p1_y_q : p1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      p2_x_q    <= p1_x_q[SAMPLE_WIDTH-1:0];
      p2_ay_q   <= abs_y[SAMPLE_WIDTH-1:0];
      p2_y_q    <= p1_y_q;
      p2_half_q <= p1_half_q;
      p2_zero_q <= p1_zero_q;
    end
  end

  // Normalization, coarse half: shift by 32, 16 and 8 while the top of the magnitude is clear.
  logic [NORM_WIDTH-2:0]        na_m;
  logic [NORM_WIDTH-2:0]        na_x;
  logic signed [NORM_WIDTH-1:0] na_y;
  logic                         p3_valid_q;
  logic [NORM_WIDTH-2:0]        p3_m_q;
  logic [NORM_WIDTH-2:0]        p3_x_q;
  logic signed [NORM_WIDTH-1:0] p3_y_q;
  logic                         p3_half_q;
  logic                         p3_zero_q;

  always_comb begin
    na_m = {{PAD_W{1'b0}}, (p2_x_q > p2_ay_q) ? p2_x_q : p2_ay_q};
    na_x = {{PAD_W{1'b0}}, p2_x_q};
    na_y = {{PAD_W{p2_y_q[SAMPLE_WIDTH]}}, p2_y_q};
    if (na_m[NORM_MSB -: 32] == '0) begin
      na_m = na_m << 32;
      na_x = na_x << 32;
      na_y = na_y <<< 32;
    end
    if (na_m[NORM_MSB -: 16] == '0) begin
      na_m = na_m << 16;
      na_x = na_x << 16;
      na_y = na_y <<< 16;
    end
    if (na_m[NORM_MSB -: 8] == '0) begin
      na_m = na_m << 8;
      na_x = na_x << 8;
      na_y = na_y <<< 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_valid_q) begin
      p3_m_q    <= na_m;
      p3_x_q    <= na_x;
      p3_y_q    <= na_y;
      p3_half_q <= p2_half_q;
      p3_zero_q <= p2_zero_q;
    end
  end

  // Normalization, fine half: shift by 4, 2 and 1, then start the rotation word.
  logic [NORM_WIDTH-2:0]        nb_m;
  logic [NORM_WIDTH-2:0]        nb_x;
  logic signed [NORM_WIDTH-1:0] nb_y;
  hmd_vec_t                     p4_vec_d;
  hmd_vec_t                     p4_vec_q;
  logic                         p4_valid_q;

  always_comb begin
    nb_m = p3_m_q;
    nb_x = p3_x_q;
    nb_y = p3_y_q;
    if (nb_m[NORM_MSB -: 4] == '0) begin
      nb_m = nb_m << 4;
      nb_x = nb_x << 4;
      nb_y = nb_y <<< 4;
    end
    if (nb_m[NORM_MSB -: 2] == '0) begin
      nb_m = nb_m << 2;
      nb_x = nb_x << 2;
      nb_y = nb_y <<< 2;
    end
    if (!nb_m[NORM_MSB]) begin
      nb_m = nb_m << 1;
      nb_x = nb_x << 1;
      nb_y = nb_y <<< 1;
    end
    p4_vec_d.zero = p3_zero_q;
    p4_vec_d.x    = {{(CORDIC_WIDTH - NORM_WIDTH + 1){1'b0}}, nb_x};
    p4_vec_d.y    = {{(CORDIC_WIDTH - NORM_WIDTH){nb_y[NORM_WIDTH-1]}}, nb_y};
    p4_vec_d.z    = p3_half_q ? {1'b1, {(ANGLE_WIDTH - 1){1'b0}}} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_valid_q) begin
      p4_vec_q <= p4_vec_d;
    end
  end

  // Rotation pipeline, one micro-rotation per stage.
  logic     stage_valid [CORDIC_STEPS+1];
  hmd_vec_t stage_vec   [CORDIC_STEPS+1];

  assign stage_valid[0] = p4_valid_q;
  assign stage_vec[0]   = p4_vec_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    hmd_cordic_stage #(
      .STEP (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .vec_i   (stage_vec[g]),
      .valid_o (stage_valid[g+1]),
      .vec_o   (stage_vec[g+1])
    );
  end

  // Scale stage: the angle in turns times 360 * 2^FRACTION_BITS, as two partial products.
  hmd_vec_t            rot_vec;
  logic [PROD_W-1:0]   prod_hi_d;
  logic [PROD_W-1:0]   prod_lo_d;
  logic                mul_valid_q;
  logic [PROD_W-1:0]   prod_hi_q;
  logic [PROD_W-1:0]   prod_lo_q;
  logic                mul_zero_q;

  assign rot_vec   = stage_vec[CORDIC_STEPS];
  assign prod_hi_d = PROD_W'(rot_vec.z[ANGLE_WIDTH-1:32]) * PROD_W'(FULL);
  assign prod_lo_d = PROD_W'(rot_vec.z[31:0]) * PROD_W'(FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= stage_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_valid[CORDIC_STEPS]) begin
      prod_hi_q  <= prod_hi_d;
      prod_lo_q  <= prod_lo_d;
      mul_zero_q <= rot_vec.zero;
    end
  end

  // Round to nearest, wrap a full circle to zero, and force zero for the zero vector.
  logic [SUM_W-1:0] round_sum;
  logic [HW:0]      round_r;
  logic [HW-1:0]    heading_d;
  logic             out_valid_q;
  logic [HW-1:0]    heading_q;

  assign round_sum = SUM_W'(prod_hi_q) + (SUM_W'(1) << 31) + SUM_W'(prod_lo_q >> 32);
  assign round_r   = round_sum[SUM_W-1:32];
  assign heading_d = (mul_zero_q || (round_r >= {1'b0, FULL})) ? '0 : round_r[HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q) begin
      heading_q <= heading_d;
    end
  end

  assign done_o    = out_valid_q;
  assign heading_o = heading_q;

endmodule

>>> hdl/hmd_checker.sv
// Port-level checks of the heading block: fixed latency, no stray results, range, zero vector.
// Bound to magnetometer_heading_degrees_top; depends on nothing else.
module hmd_checker #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 6
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  input logic                          done_o,
  input logic [9+FRACTION_BITS-1:0]    heading_o
);

  localparam int unsigned HW      = 9 + FRACTION_BITS;
  localparam int unsigned LATENCY = 68;
  localparam logic [HW-1:0] FULL  = HW'(360) << FRACTION_BITS;

  // Every accepted word yields its result after the pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted word gave no result after the pipeline latency");

  // No result without a word accepted the same latency earlier.
  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching accepted word");

  // The heading stays below a full circle.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_o < FULL))
    else $error("heading at or above 360 degrees");

  // The zero vector gives heading zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mag_x_i == '0) && (mag_y_i == '0))
      |-> ##LATENCY (heading_o == '0))
    else $error("zero vector did not give heading zero");

endmodule

bind magnetometer_heading_degrees_top hmd_checker #(
  .SAMPLE_WIDTH  (SAMPLE_WIDTH),
  .FRACTION_BITS (FRACTION_BITS)
) u_hmd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .mag_x_i   (mag_x_i),
  .mag_y_i   (mag_y_i),
  .done_o    (done_o),
  .heading_o (heading_o)
);
